FILE: sv/pvc_pkg.sv
// Shared types and constants of the piecewise linear voltage calibrator.
package pvc_pkg;

	localparam int TABLE_ROWS_DEF = 16;
	localparam int CHANNELS_DEF   = 6;
	localparam int ADC_BITS_DEF   = 10;

	localparam int              APB_AW     = 2;
	localparam logic [APB_AW-1:0] REG_ROWS_ADDR = 2'd0;
	localparam logic [4:0]      ROWS_RESET = 5'd2;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [3:0]  row_index;
		logic [9:0]  breakpoint_code;
		logic [15:0] breakpoint_volts;
		logic [2:0]  channel;
		logic [9:0]  sample_code;
	} item_t;

	typedef struct packed {
		logic [2:0]  out_channel;
		logic [15:0] volts;
		logic        in_range;
		logic        saturated;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic capture;
		logic rd_en;
		logic mul;
		logic div;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic dx_zero;
	} dp_stat_t;

endpackage

FILE: sv/pvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/pvc_ctrl.sv
// Controller state machine: table scan, multiply, serial divide and result sequencing.
module pvc_ctrl #(
	parameter int TABLE_ROWS = 16,
	parameter int CHANNELS   = 6,
	parameter int ADC_BITS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pvc_pkg::item_t                item,
	input  logic [4:0]                    rows_in_use,
	input  pvc_pkg::dp_stat_t             stat,
	output pvc_pkg::ctrl_cmd_t            cmd,
	output logic [$clog2(TABLE_ROWS)-1:0] rd_addr,
	output logic                          busy
);
	import pvc_pkg::*;

	localparam int AW  = $clog2(TABLE_ROWS);
	localparam int CW  = (ADC_BITS < 10) ? ADC_BITS : 10;
	localparam int PW  = CW + 16;
	localparam int DCW = $clog2(PW);
	localparam logic [8:0] TR9 = 9'(TABLE_ROWS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t         state_q, state_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic [DCW-1:0] dcnt_q, dcnt_d;
	logic [8:0]     rows_ext, rows_eff;
	logic [AW-1:0]  last_row;
	logic           is_sample, is_load;

	always_comb begin
		rows_ext = 9'(rows_in_use);
		if (rows_ext < 9'd2) begin
			rows_eff = 9'd2;
		end else if (rows_ext > TR9) begin
			rows_eff = TR9;
		end else begin
			rows_eff = rows_ext;
		end
		last_row = AW'(rows_eff - 9'd1);
	end

	assign is_sample = (item.func == FUNC_SAMPLE) && (5'(item.channel) < 5'(CHANNELS));
	assign is_load   = (item.func == FUNC_LOAD) && (9'(item.row_index) < TR9);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		dcnt_d  = dcnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = is_load;
					if (is_sample) begin
						cmd.capture = 1'b1;
						idx_d       = '0;
						state_d     = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (idx_q == last_row) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				dcnt_d  = '0;
				if (stat.hit && !stat.dx_zero) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				dcnt_d  = dcnt_q + 1'b1;
				if (dcnt_q == DCW'(PW - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dcnt_q  <= dcnt_d;
		end
	end

	assign rd_addr = idx_q;
	assign busy    = (state_q != ST_IDLE);

endmodule

FILE: sv/pvc_dp.sv
// Datapath: breakpoint table, segment match, multiplier, restoring divider and held values.
module pvc_dp #(
	parameter int TABLE_ROWS = 16,
	parameter int CHANNELS   = 6,
	parameter int ADC_BITS   = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvc_pkg::item_t                item,
	input  pvc_pkg::ctrl_cmd_t            cmd,
	input  logic [$clog2(TABLE_ROWS)-1:0] rd_addr,
	output pvc_pkg::dp_stat_t             stat,
	output pvc_pkg::result_t              result,
	output logic                          result_valid
);
	import pvc_pkg::*;

	localparam int AW = $clog2(TABLE_ROWS);
	localparam int CW = (ADC_BITS < 10) ? ADC_BITS : 10;
	localparam int PW = CW + 16;
	localparam int RW = CW + 16;
	localparam int HW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [RW-1:0] rdata;
	logic [CW-1:0] rd_code;
	logic [15:0]   rd_volts;

	logic          rd_vld_s1, rd_row0_s1;
	logic [9:0]    x_q;
	logic [2:0]    ch_q;
	logic [CW-1:0] px_q;
	logic [15:0]   py_q;
	logic          hit_q, neg_q;
	logic [CW-1:0] off_q, dx_q, rem_q;
	logic [15:0]   dy_q, y1_q;
	logic [PW-1:0] prod_q;
	logic [15:0]   held_q [CHANNELS];
	logic          seg_hit;
	logic [CW:0]   trial;
	logic          ge;
	logic [17:0]   sum;
	result_t       res_d;

	pvc_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_ROWS)
	) u_table (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(AW'(item.row_index)),
		.wdata({item.breakpoint_code[CW-1:0], item.breakpoint_volts}),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign rd_code  = rdata[RW-1:16];
	assign rd_volts = rdata[15:0];

	// A segment pairs the previous row read with the current one; later hits win.
	assign seg_hit = rd_vld_s1 && !rd_row0_s1
		&& (10'(px_q) <= x_q) && (x_q <= 10'(rd_code));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_row0_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			rd_vld_s1  <= cmd.rd_en;
			rd_row0_s1 <= cmd.rd_en && (rd_addr == '0);
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (seg_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q  <= item.sample_code;
			ch_q <= item.channel;
		end
		if (rd_vld_s1) begin
			px_q <= rd_code;
			py_q <= rd_volts;
		end
		if (seg_hit) begin
			off_q <= CW'(x_q - 10'(px_q));
			dx_q  <= rd_code - px_q;
			y1_q  <= py_q;
			neg_q <= rd_volts < py_q;
			dy_q  <= (rd_volts < py_q) ? (py_q - rd_volts) : (rd_volts - py_q);
		end
	end

	assign stat.hit     = hit_q;
	assign stat.dx_zero = (dx_q == '0);

	// Restoring division: the product register shifts out dividend bits and
	// takes in quotient bits, one per cycle.
	assign trial = {rem_q, prod_q[PW-1]};
	assign ge    = trial >= {1'b0, dx_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(off_q * dy_q);
			rem_q  <= '0;
		end else if (cmd.div) begin
			prod_q <= {prod_q[PW-2:0], ge};
			rem_q  <= ge ? CW'(trial - {1'b0, dx_q}) : trial[CW-1:0];
		end
	end

	always_comb begin
		sum = neg_q ? ({2'b00, y1_q} - {2'b00, prod_q[15:0]})
			: ({2'b00, y1_q} + {2'b00, prod_q[15:0]});
		res_d.out_channel = ch_q;
		res_d.in_range    = hit_q;
		res_d.saturated   = 1'b0;
		if (!hit_q) begin
			res_d.volts = held_q[HW'(ch_q)];
		end else if (dx_q == '0) begin
			res_d.volts = y1_q;
		end else if (sum[17]) begin
			res_d.volts     = 16'h0000;
			res_d.saturated = 1'b1;
		end else if (sum[16]) begin
			res_d.volts     = 16'hffff;
			res_d.saturated = 1'b1;
		end else begin
			res_d.volts = sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				held_q[c] <= '0;
			end
		end else begin
			result_valid <= cmd.finish;
			if (cmd.finish && hit_q) begin
				held_q[HW'(ch_q)] <= res_d.volts;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result <= res_d;
		end
	end

endmodule

FILE: sv/piecewise_linear_voltage_calibrator.sv
// Top level of the piecewise linear voltage calibrator: register port, controller and datapath.
//
//  channel   ports                                 handshake
//  -------   -----------------------------------   ------------------------------
//  item      start, busy, item                     taken when start & !busy
//  result    result_valid, result                  one-cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata      write on psel & penable & pwrite
//            prdata pready                         pready always high
//
// A load item writes its table row in the cycle it is taken and leaves busy low.
// A sample item reads each of the rows in use, that count being clamped to
// 2..TABLE_ROWS, one table read per cycle, then multiplies and takes one quotient
// bit per cycle in the restoring divider.
// A sample that matches no segment or lands on a zero-width one skips the divider.
// Reset clears the row count to 2 and the held voltages to zero; table rows are
// undefined until loaded. The receiver cannot stall the result.
module piecewise_linear_voltage_calibrator #(
	parameter int TABLE_ROWS = pvc_pkg::TABLE_ROWS_DEF,
	parameter int CHANNELS   = pvc_pkg::CHANNELS_DEF,
	parameter int ADC_BITS   = pvc_pkg::ADC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pvc_pkg::item_t             item,
	output logic                       result_valid,
	output pvc_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pvc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import pvc_pkg::*;

	localparam int AW = $clog2(TABLE_ROWS);

	logic [4:0]    rows_q;
	ctrl_cmd_t     cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_ROWS_ADDR)) begin
			rows_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr == REG_ROWS_ADDR) ? {27'd0, rows_q} : 32'd0;

	pvc_ctrl #(
		.TABLE_ROWS(TABLE_ROWS),
		.CHANNELS  (CHANNELS),
		.ADC_BITS  (ADC_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.rows_in_use(rows_q),
		.stat       (stat),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.busy       (busy)
	);

	pvc_dp #(
		.TABLE_ROWS(TABLE_ROWS),
		.CHANNELS  (CHANNELS),
		.ADC_BITS  (ADC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.stat        (stat),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule
